// ===== hdl/lst_pkg.sv =====
// Types, constants and helpers shared by the layer strip triangulator.
package lst_pkg;

  localparam int MaxNodes  = 1024;
  localparam int CoordBits = 16;
  localparam int CoordW    = 16;
  localparam int CoordEff  = (CoordBits < CoordW) ? CoordBits : CoordW;
  localparam int PosW      = $clog2(MaxNodes);
  localparam int CntW      = $clog2(MaxNodes + 1);
  localparam int AddrW     = PosW + 1;
  localparam int PosOutW   = 10;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * CoordW;
  localparam int SumW      = SqW + 2;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic FromOld = 1'b0;
  localparam logic FromNew = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     end_of_layer;
  } in_t;

  typedef struct packed {
    logic               a_from_new;
    logic [PosOutW-1:0] a_pos;
    logic               b_from_new;
    logic [PosOutW-1:0] b_pos;
    logic               c_from_new;
    logic [PosOutW-1:0] c_pos;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] c;
  } point_t;

  typedef struct packed {
    point_t             pt;
    logic               in_range;
    logic               old_valid;
    logic               emit;
    logic [PosOutW-1:0] pos;
  } stage1_t;

  typedef struct packed {
    logic               short_old_new;
    logic [PosOutW-1:0] a_pos;
    logic [PosOutW-1:0] i_pos;
  } quad_t;

  function automatic logic [CoordW-1:0] coord_fix(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] r;
    for (int k = 0; k < CoordW; k++) begin
      r[k] = (k < CoordEff) ? v[k] : v[CoordEff-1];
    end
    return r;
  endfunction

endpackage

// ===== hdl/layer_strip_triangulator_top.sv =====
// Top level of the layer strip triangulator.
// Takes one point per beat and, for each point that closes a quad with the previous
// layer, gives two triangle beats: the first once the point has passed both stage
// registers and the quad queue, the second on the next cycle the output is not stalled.
// Points that close no quad (the first of a layer, the first layer after reset, surplus
// or overlong points) pass at one per cycle while in_stall is low; a run of quads is
// paced by the single triangle output port. The previous layer sits in one bank of a
// 2 x 1024 x 48-bit store with one write and one registered read per cycle; in_stall
// rises when the four-entry quad queue plus the points still in the two pipeline
// stages would fill it. No clearing pass is needed after reset.
module layer_strip_triangulator_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lst_pkg::out_t out_data
);

  logic             s1_valid;
  lst_pkg::stage1_t s1;
  lst_pkg::point_t  old_rd;
  logic             s2_valid;
  logic             push;
  lst_pkg::quad_t   quad;

  lst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1       (s1),
    .old_rd   (old_rd)
  );

  lst_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .old_rd   (old_rd),
    .s2_valid (s2_valid),
    .push     (push),
    .quad     (quad)
  );

  lst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s2_valid  (s2_valid),
    .push      (push),
    .quad      (quad),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/lst_front.sv =====
// Input register, position and bank control, and the two-bank layer store.
module lst_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  lst_pkg::in_t     in_data,
  output logic             s1_valid,
  output lst_pkg::stage1_t s1,
  output lst_pkg::point_t  old_rd
);

  logic [lst_pkg::CoordW*3-1:0] mem [2*lst_pkg::MaxNodes];

  logic                      bank_r;
  logic [lst_pkg::CntW-1:0]  pos_r;
  logic [lst_pkg::CntW-1:0]  old_cnt_r;
  logic                      s1_valid_r;
  lst_pkg::stage1_t          s1_r;
  lst_pkg::point_t           rd_r;

  logic                      accept;
  logic                      in_range;
  logic                      old_valid;
  logic [lst_pkg::CntW-1:0]  pos_nxt;
  logic [lst_pkg::AddrW-1:0] waddr;
  logic [lst_pkg::AddrW-1:0] raddr;
  lst_pkg::point_t           pt;

  assign accept    = in_valid & ~in_stall;
  assign in_range  = pos_r < lst_pkg::CntW'(lst_pkg::MaxNodes);
  assign old_valid = pos_r < old_cnt_r;
  assign pos_nxt   = in_range ? pos_r + lst_pkg::CntW'(1) : pos_r;
  assign waddr     = {~bank_r, pos_r[lst_pkg::PosW-1:0]};
  assign raddr     = {bank_r, pos_r[lst_pkg::PosW-1:0]};

  always_comb begin
    pt.c[2] = lst_pkg::coord_fix(in_data.x);
    pt.c[1] = lst_pkg::coord_fix(in_data.y);
    pt.c[0] = lst_pkg::coord_fix(in_data.z);
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      mem[waddr] <= pt;
    end
    if (accept) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      pos_r      <= '0;
      old_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (in_data.end_of_layer) begin
          old_cnt_r <= pos_nxt;
          bank_r    <= ~bank_r;
          pos_r     <= '0;
        end else begin
          pos_r <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.pt        <= pt;
      s1_r.in_range  <= in_range;
      s1_r.old_valid <= old_valid;
      s1_r.emit      <= old_valid && (pos_r != '0);
      s1_r.pos       <= lst_pkg::PosOutW'(pos_r);
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign old_rd   = rd_r;

endmodule

// ===== hdl/lst_split.sv =====
// Held corner points, diagonal squares and the shorter-diagonal decision.
module lst_split (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  input  lst_pkg::stage1_t s1,
  input  lst_pkg::point_t  old_rd,
  output logic             s2_valid,
  output logic             push,
  output lst_pkg::quad_t   quad
);

  lst_pkg::point_t              held_new_r;
  lst_pkg::point_t              held_old_r;
  logic                         s2_valid_r;
  logic                         s2_emit_r;
  logic [lst_pkg::PosOutW-1:0]  s2_pos_r;
  logic [2:0][lst_pkg::SqW-1:0] sq_a_r;
  logic [2:0][lst_pkg::SqW-1:0] sq_b_r;

  lst_pkg::point_t                old_here;
  logic signed [lst_pkg::DiffW-1:0] da [3];
  logic signed [lst_pkg::DiffW-1:0] db [3];
  logic [2:0][lst_pkg::SqW-1:0]   sq_a;
  logic [2:0][lst_pkg::SqW-1:0]   sq_b;
  logic [lst_pkg::SumW-1:0]       sum_a;
  logic [lst_pkg::SumW-1:0]       sum_b;

  assign old_here = s1.old_valid ? old_rd : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      da[k] = lst_pkg::DiffW'($signed(held_old_r.c[k]))
            - lst_pkg::DiffW'($signed(s1.pt.c[k]));
      db[k] = lst_pkg::DiffW'($signed(held_new_r.c[k]))
            - lst_pkg::DiffW'($signed(old_here.c[k]));
      sq_a[k] = lst_pkg::SqW'(da[k] * da[k]);
      sq_b[k] = lst_pkg::SqW'(db[k] * db[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_new_r <= '0;
      held_old_r <= '0;
      s2_valid_r <= 1'b0;
      s2_emit_r  <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
      s2_emit_r  <= s1_valid && s1.emit;
      if (s1_valid && s1.in_range) begin
        held_new_r <= s1.pt;
        held_old_r <= old_here;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      sq_a_r   <= sq_a;
      sq_b_r   <= sq_b;
      s2_pos_r <= s1.pos;
    end
  end

  assign sum_a = lst_pkg::SumW'(sq_a_r[0]) + lst_pkg::SumW'(sq_a_r[1])
               + lst_pkg::SumW'(sq_a_r[2]);
  assign sum_b = lst_pkg::SumW'(sq_b_r[0]) + lst_pkg::SumW'(sq_b_r[1])
               + lst_pkg::SumW'(sq_b_r[2]);

  assign s2_valid           = s2_valid_r;
  assign push               = s2_valid_r && s2_emit_r;
  assign quad.short_old_new = sum_a <= sum_b;
  assign quad.i_pos         = s2_pos_r;
  assign quad.a_pos         = s2_pos_r - lst_pkg::PosOutW'(1);

endmodule

// ===== hdl/lst_queue.sv =====
// Quad queue with input credit, and the two-triangle output sequencing.
module lst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  logic           s2_valid,
  input  logic           push,
  input  lst_pkg::quad_t quad,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output lst_pkg::out_t  out_data
);

  lst_pkg::quad_t            q_r [lst_pkg::QDepth];
  logic [lst_pkg::QPtrW-1:0] wr_ptr_r;
  logic [lst_pkg::QPtrW-1:0] rd_ptr_r;
  logic [lst_pkg::QCntW-1:0] cnt_r;
  logic                      half_r;

  logic                      beat;
  logic                      pop;
  logic [lst_pkg::QCntW-1:0] pending;
  lst_pkg::quad_t            head;

  assign pending  = cnt_r + lst_pkg::QCntW'(s1_valid) + lst_pkg::QCntW'(s2_valid);
  assign in_stall = pending >= lst_pkg::QCntW'(lst_pkg::QDepth);

  assign out_valid = cnt_r != '0;
  assign beat      = out_valid & ~out_stall;
  assign pop       = beat & half_r;
  assign head      = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= quad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + lst_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + lst_pkg::QPtrW'(1);
      end
      cnt_r <= cnt_r + lst_pkg::QCntW'(push) - lst_pkg::QCntW'(pop);
      if (beat) begin
        half_r <= ~half_r;
      end
    end
  end

  always_comb begin
    out_data.a_from_new  = lst_pkg::FromOld;
    out_data.a_pos       = head.a_pos;
    out_data.b_from_new  = lst_pkg::FromNew;
    out_data.b_pos       = head.a_pos;
    out_data.c_from_new  = lst_pkg::FromOld;
    out_data.c_pos       = head.i_pos;
    out_data.last_of_run = half_r;
    if (!half_r) begin
      out_data.c_from_new = head.short_old_new ? lst_pkg::FromNew : lst_pkg::FromOld;
    end else begin
      out_data.a_from_new = head.short_old_new ? lst_pkg::FromOld : lst_pkg::FromNew;
      out_data.b_pos      = head.i_pos;
    end
  end

endmodule

// ===== hdl/lst_checker.sv =====
// Port-level checks for the layer strip triangulator, bound to the top level.
module lst_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input lst_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input lst_pkg::out_t out_data
);

  default disable iff (!rst_n);

  a_out_hold: assert property (@(posedge clk)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_first_shape: assert property (@(posedge clk)
    out_valid && !out_data.last_of_run |->
      out_data.a_from_new == lst_pkg::FromOld && out_data.b_from_new == lst_pkg::FromNew
      && out_data.b_pos == out_data.a_pos
      && out_data.c_pos == out_data.a_pos + lst_pkg::PosOutW'(1))
    else $error("first triangle of quad malformed");

  a_second_shape: assert property (@(posedge clk)
    out_valid && out_data.last_of_run |->
      out_data.b_from_new == lst_pkg::FromNew && out_data.c_from_new == lst_pkg::FromOld
      && out_data.c_pos == out_data.b_pos
      && out_data.b_pos == out_data.a_pos + lst_pkg::PosOutW'(1))
    else $error("second triangle of quad malformed");

  a_pair_order: assert property (@(posedge clk)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_valid && out_data.last_of_run
      && out_data.a_pos == $past(out_data.a_pos))
    else $error("second triangle did not follow first");

endmodule

bind layer_strip_triangulator_top lst_checker u_lst_checker (.*);

// ===== test/lst_triangle_checker.sv =====
// Checker for the layer strip triangulator: predicts triangle beats and compares them.
module lst_triangle_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  lst_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  lst_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lst_pkg::*;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vertex_t;

  vertex_t     layer_mem [2][MaxNodes];
  vertex_t     last_new;
  vertex_t     last_old;
  bit          old_side;
  int unsigned old_len;
  int unsigned next_pos;
  out_t        tri_expected [$];

  function automatic longint coord_value(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] s;
    s = v << (CoordW - CoordEff);
    return longint'($signed(s)) >>> (CoordW - CoordEff);
  endfunction

  function automatic longint sq_dist(input vertex_t p, input vertex_t q);
    longint dx, dy, dz;
    dx = p.x - q.x;
    dy = p.y - q.y;
    dz = p.z - q.z;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic out_t make_tri(input logic an, input int ap, input logic bn, input int bp,
                                    input logic cn, input int cp, input logic last);
    out_t t;
    t.a_from_new  = an;
    t.a_pos       = PosOutW'(ap);
    t.b_from_new  = bn;
    t.b_pos       = PosOutW'(bp);
    t.c_from_new  = cn;
    t.c_pos       = PosOutW'(cp);
    t.last_of_run = last;
    return t;
  endfunction

  function automatic void queue_tri(input out_t t);
    tri_expected = {tri_expected, t};
  endfunction

  task automatic predict_triangles(input in_t beat);
    vertex_t     p;
    vertex_t     old_here;
    int unsigned pos;
    bit          new_side;
    pos        = next_pos;
    new_side   = ~old_side;
    p.x        = coord_value(beat.x);
    p.y        = coord_value(beat.y);
    p.z        = coord_value(beat.z);
    old_here   = '0;
    if (pos < MaxNodes) begin
      if (pos < old_len) old_here = layer_mem[old_side][pos];
      if (pos >= 1 && pos < old_len) begin
        if (sq_dist(last_old, p) <= sq_dist(last_new, old_here)) begin
          queue_tri(make_tri(FromOld, pos - 1, FromNew, pos - 1, FromNew, pos, 1'b0));
          queue_tri(make_tri(FromOld, pos - 1, FromNew, pos, FromOld, pos, 1'b1));
        end else begin
          queue_tri(make_tri(FromOld, pos - 1, FromNew, pos - 1, FromOld, pos, 1'b0));
          queue_tri(make_tri(FromNew, pos - 1, FromNew, pos, FromOld, pos, 1'b1));
        end
      end
      layer_mem[new_side][pos] = p;
      last_new = p;
      last_old = old_here;
      next_pos = pos + 1;
    end
    if (beat.end_of_layer) begin
      old_len  = next_pos;
      old_side = new_side;
      next_pos = 0;
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst_n) begin
      old_side = 1'b0;
      old_len  = 0;
      next_pos = 0;
      last_new = '0;
      last_old = '0;
      tri_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tri_expected.size() == 0) begin
          $display("%0t: triangle beat expected none, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = tri_expected.pop_front();
          check_field("a_from_new", want.a_from_new, out_data.a_from_new);
          check_field("a_pos", want.a_pos, out_data.a_pos);
          check_field("b_from_new", want.b_from_new, out_data.b_from_new);
          check_field("b_pos", want.b_pos, out_data.b_pos);
          check_field("c_from_new", want.c_from_new, out_data.c_from_new);
          check_field("c_pos", want.c_pos, out_data.c_pos);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
      if (in_valid && !in_stall) predict_triangles(in_data);
    end
    pending = tri_expected.size();
  end

endmodule

// ===== test/layer_strip_triangulator_top_tb.sv =====
// Testbench top for the layer strip triangulator: drives point beats, shapes stalls, gives the verdict.
module layer_strip_triangulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lst_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int HoldOffCycles = 400;
  localparam int TailCycles    = 20;

  typedef enum int {StyleFull, StyleTies, StyleCorner, StyleMixed} coord_style_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   sent;
  bit   tx_burst;
  bit   rx_burst;
  bit   hold_req;

  always #5ns clk = ~clk;

  layer_strip_triangulator_top u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  lst_triangle_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t make_point(input int x, input int y, input int z, input bit eol);
    in_t p;
    p.x            = CoordW'(x);
    p.y            = CoordW'(y);
    p.z            = CoordW'(z);
    p.end_of_layer = eol;
    return p;
  endfunction

  function automatic int pick_coord(input coord_style_e style);
    coord_style_e s;
    s = style;
    if (s == StyleMixed) s = coord_style_e'($urandom_range(0, 2));
    case (s)
      StyleTies: return int'($urandom_range(0, 4)) - 2;
      StyleCorner: begin
        case ($urandom_range(0, 6))
          0: return -32768;
          1: return -32767;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return 32766;
          default: return 32767;
        endcase
      end
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 1;
    if (r < 90) return $urandom_range(2, 20);
    return $urandom_range(21, 70);
  endfunction

  task automatic send_point(input in_t p);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
  endtask

  task automatic send_layer(input int len, input coord_style_e style);
    for (int i = 0; i < len; i++) begin
      send_point(make_point(pick_coord(style), pick_coord(style), pick_coord(style),
                            i == len - 1));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic random_layers(input int upto);
    while (sent < upto) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) drain();
      send_layer(random_len(), coord_style_e'($urandom_range(0, 3)));
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldOffCycles;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) stall_left = rx_burst ? 0 : $urandom_range(0, 10);
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first layer after reset: no partner
    send_point(make_point(-32768, -32768, -32768, 1'b0));
    send_point(make_point(32767, 32767, 32767, 1'b0));
    send_point(make_point(0, 0, 0, 1'b1));
    // tie on the first quad, surplus point at the end
    send_point(make_point(32767, 32767, 32767, 1'b0));
    send_point(make_point(-32768, -32768, -32768, 1'b0));
    send_point(make_point(1, 2, 3, 1'b0));
    send_point(make_point(-1, -2, -3, 1'b1));
    // single-point layer, then a layer that closes no quad against it
    send_point(make_point(5, -5, 7, 1'b1));
    send_point(make_point(9, 9, 9, 1'b0));
    send_point(make_point(-9, 9, -9, 1'b0));
    send_point(make_point(3, 3, 3, 1'b1));
    send_point(make_point(0, 0, 0, 1'b0));
    send_point(make_point(0, 0, 0, 1'b0));
    send_point(make_point(0, 0, 0, 1'b1));
    // other diagonal, then the widest distances
    send_point(make_point(0, 0, 0, 1'b0));
    send_point(make_point(100, 0, 0, 1'b1));
    send_point(make_point(-32768, 32767, -32768, 1'b0));
    send_point(make_point(32767, -32768, 32767, 1'b1));
    drain();

    random_layers(100);

    // overlong layer, then hold the output while quads against it pile up
    tx_burst = 1'b1;
    rx_burst = 1'b0;
    send_layer(MaxNodes + 1, StyleMixed);
    hold_req = 1'b1;
    send_layer(600, StyleMixed);
    drain();

    random_layers(1800);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
